// ===== rtl/core/fbfc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbfc_pkg
// Shared constants for the five-byte number converter.
// ----------------------------------------------------------------------------
package fbfc_pkg;
    localparam int PACKED_W = 40;
    localparam int DOUBLE_W = 64;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FIN   = 2'd3;

    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_ENCODE = 1'b1;
endpackage

// ===== rtl/core/fbfc_decode.sv =====
// ----------------------------------------------------------------------------
// fbfc_decode
// Five-byte number to double bit pattern, combinational.
// ----------------------------------------------------------------------------
module fbfc_decode
    import fbfc_pkg::*;
(
    input  logic [PACKED_W-1:0] packed_in,
    output logic [DOUBLE_W-1:0] double_out
);
    logic [7:0]  b0, b1, b2, b3, b4;
    logic [15:0] v;
    logic [16:0] mag;
    logic        is_int;
    logic        neg;
    logic [4:0]  t;
    logic [51:0] frac;
    logic [10:0] ex;

    always_comb
    begin
        b0 = packed_in[7:0];
        b1 = packed_in[15:8];
        b2 = packed_in[23:16];
        b3 = packed_in[31:24];
        b4 = packed_in[39:32];
        v  = {b3, b2};
        is_int = (b0 == 8'h00) && (b1 == 8'h00 || b1 == 8'hFF) && (b4 == 8'h00);
        neg = (b1 != 8'h00);
        mag = neg ? (17'd65536 - {1'b0, v}) : {1'b0, v};
        t = 5'd0;
        for (int i = 1; i < 17; i++)
        begin
            if (mag[i])
                t = 5'(i);
        end
        frac = 52'({35'd0, mag} << (7'd52 - {2'd0, t}));
        ex = 11'({3'd0, b0} + 11'd894);
        if (is_int)
        begin
            if (mag == 17'd0)
                double_out = '0;
            else
                double_out = {neg, 11'(11'd1023 + {6'd0, t}), frac};
        end
        else
        begin
            double_out = {b1[7], ex, b1[6:0], b2, b3, b4, 21'd0};
        end
    end
endmodule

// ===== rtl/core/fbfc_encode.sv =====
// ----------------------------------------------------------------------------
// fbfc_encode
// Double bit pattern to five-byte number with status, combinational.
// ----------------------------------------------------------------------------
module fbfc_encode
    import fbfc_pkg::*;
(
    input  logic [DOUBLE_W-1:0] double_in,
    output logic [PACKED_W-1:0] packed_out,
    output logic [STATUS_W-1:0] status
);
    logic        sign;
    logic [10:0] ex;
    logic [51:0] frac;
    logic [52:0] sig;
    logic [5:0]  t;
    logic [6:0]  sh;
    logic [52:0] lowmask;
    logic [16:0] imag;
    logic [15:0] ilow;
    logic [52:0] norm;
    logic [32:0] m;
    logic        rbit, sticky;
    logic signed [12:0] e;

    always_comb
    begin
        sign = double_in[63];
        ex   = double_in[62:52];
        frac = double_in[51:0];
        sig  = (ex == 11'd0) ? {1'b0, frac} : {1'b1, frac};
        sh   = 7'd52 - 7'(ex - 11'd1023);
        lowmask = (53'd1 << sh) - 53'd1;
        imag = 17'({1'b1, frac} >> sh);
        ilow = sign ? 16'(17'd65536 - imag) : imag[15:0];
        t = 6'd0;
        for (int i = 1; i < 53; i++)
        begin
            if (sig[i])
                t = 6'(i);
        end
        // normalise so the leading one sits at bit 52
        norm = sig << (6'd52 - t);
        m = {1'b0, norm[52:21]};
        rbit = norm[20];
        sticky = |norm[19:0];
        if (rbit && (sticky || m[0]))
            m = m + 33'd1;
        if (ex == 11'd0)
            e = 13'sd0 + $signed({7'd0, t}) - 13'sd1073;
        else
            e = $signed({2'd0, ex}) + $signed({7'd0, t}) - 13'sd1074;
        if (m[32])
        begin
            m = m >> 1;
            e = e + 13'sd1;
        end
        packed_out = '0;
        status = ST_OK;
        if (ex == 11'h7FF)
            status = ST_NOT_FIN;
        else if (ex == 11'd0 && frac == 52'd0)
            status = ST_OK;
        else if (ex >= 11'd1023 && ex <= 11'd1038 && (sig & lowmask) == 53'd0)
            packed_out = {8'd0, ilow, (sign ? 8'hFF : 8'h00), 8'd0};
        else if (e > 13'sd127)
            status = ST_TOO_BIG;
        else if (e < -13'sd127)
            status = ST_TOO_SMALL;
        else
            packed_out = {m[7:0], m[15:8], m[23:16], sign, m[30:24],
                          8'(e + 13'sd128)};
    end
endmodule

// ===== rtl/core/five_byte_float_converter.sv =====
// ----------------------------------------------------------------------------
// five_byte_float_converter
// Converts between IEEE doubles and the five-byte BASIC number format.
// ----------------------------------------------------------------------------
// Input channel: valid/ready with mode, packed_in and double_in. mode 0
// decodes packed_in into double_out; mode 1 encodes double_in into
// packed_out with status (0 ok, 1 too big, 2 too small, 3 not finite).
// Output channel: valid/ready with double_out, packed_out and status;
// fields not used by the mode read zero.
// The input is registered, the conversion is one combinational pass, and
// the result register feeds the output: a transaction goes from the input
// register to the result register, one per cycle while out_ready is high.
// When the receiver stalls, the result register holds and in_ready stays
// high while the input stage is empty or can move forward; both stages
// stall once full. Reset empties both stages.
// ----------------------------------------------------------------------------
module five_byte_float_converter
    import fbfc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [PACKED_W-1:0] packed_in,
    input  logic [DOUBLE_W-1:0] double_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DOUBLE_W-1:0] double_out,
    output logic [PACKED_W-1:0] packed_out,
    output logic [STATUS_W-1:0] status
);
    logic                s1_valid_reg;
    logic                mode_reg;
    logic [PACKED_W-1:0] packed_reg;
    logic [DOUBLE_W-1:0] double_reg;
    logic                out_valid_reg;
    logic [DOUBLE_W-1:0] dout_reg;
    logic [PACKED_W-1:0] pout_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [DOUBLE_W-1:0] dec_d;
    logic [PACKED_W-1:0] enc_p;
    logic [STATUS_W-1:0] enc_s;
    logic                s2_load;

    fbfc_decode u_dec (.packed_in(packed_reg), .double_out(dec_d));
    fbfc_encode u_enc (.double_in(double_reg), .packed_out(enc_p), .status(enc_s));

    assign s2_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mode_reg   <= mode;
            packed_reg <= packed_in;
            double_reg <= double_in;
        end
        if (s2_load)
        begin
            if (mode_reg == MODE_ENCODE)
            begin
                dout_reg   <= '0;
                pout_reg   <= enc_p;
                status_reg <= enc_s;
            end
            else
            begin
                dout_reg   <= dec_d;
                pout_reg   <= '0;
                status_reg <= ST_OK;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign double_out = dout_reg;
    assign packed_out = pout_reg;
    assign status     = status_reg;
endmodule
